// ===== design/hlmd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hlmd_pkg
// shared types and constants for the header/length message deframer
// ----------------------------------------------------------------------------
package hlmd_pkg;

  typedef enum logic [2:0] {
    KIND_HDR_BYTE  = 3'd0,
    KIND_HDR_END   = 3'd1,
    KIND_PAY_BYTE  = 3'd2,
    KIND_HDRS_DONE = 3'd3,
    KIND_MALFORMED = 3'd4
  } kind_t;

  typedef enum logic {
    PH_HEADERS = 1'b0,
    PH_PAYLOAD = 1'b1
  } phase_t;

  // utf-8 decoder state: what the next byte of a sequence must be
  typedef enum logic [2:0] {
    U8_LEAD      = 3'd0,
    U8_OWE_ONE   = 3'd1,
    U8_OWE_TWO   = 3'd2,
    U8_AFTER_E0  = 3'd3,
    U8_AFTER_ED  = 3'd4,
    U8_AFTER_F0  = 3'd5,
    U8_AFTER_F13 = 3'd6,
    U8_AFTER_F4  = 3'd7
  } utf8_state_t;

  localparam logic [7:0] CHR_LF    = 8'h0A;
  localparam logic [7:0] CHR_COLON = 8'h3A;
  localparam logic [7:0] CHR_SPACE = 8'h20;
  localparam logic [7:0] CHR_ZERO  = 8'h30;
  localparam logic [7:0] CHR_NINE  = 8'h39;

  localparam int unsigned PREFIX_LEN = 8;

  // "Length: " one character at a time
  function automatic logic [7:0] prefix_char(input logic [2:0] pos);
    logic [7:0] c;
    unique case (pos)
      3'd0:    c = 8'h4C; // L
      3'd1:    c = 8'h65; // e
      3'd2:    c = 8'h6E; // n
      3'd3:    c = 8'h67; // g
      3'd4:    c = 8'h74; // t
      3'd5:    c = 8'h68; // h
      3'd6:    c = 8'h3A; // :
      default: c = 8'h20; // space
    endcase
    return c;
  endfunction

endpackage

// ===== design/hlmd_utf8.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hlmd_utf8
// one-byte step of a strict utf-8 validator (no overlongs, surrogates or
// code points above U+10FFFF)
// ----------------------------------------------------------------------------
module hlmd_utf8
  import hlmd_pkg::*;
(
  input  utf8_state_t state_i,
  input  logic [7:0]  byte_i,
  output utf8_state_t state_o,
  output logic        bad_o
);

  logic cont;

  assign cont = (byte_i[7:6] == 2'b10);

  always_comb begin
    state_o = U8_LEAD;
    bad_o   = 1'b0;
    unique case (state_i)
      U8_LEAD: begin
        if (byte_i < 8'h80) begin
          state_o = U8_LEAD;
        end else if (byte_i >= 8'hC2 && byte_i <= 8'hDF) begin
          state_o = U8_OWE_ONE;
        end else if (byte_i == 8'hE0) begin
          state_o = U8_AFTER_E0;
        end else if (byte_i == 8'hED) begin
          state_o = U8_AFTER_ED;
        end else if (byte_i >= 8'hE1 && byte_i <= 8'hEF) begin
          state_o = U8_OWE_TWO;
        end else if (byte_i == 8'hF0) begin
          state_o = U8_AFTER_F0;
        end else if (byte_i >= 8'hF1 && byte_i <= 8'hF3) begin
          state_o = U8_AFTER_F13;
        end else if (byte_i == 8'hF4) begin
          state_o = U8_AFTER_F4;
        end else begin
          bad_o = 1'b1;
        end
      end
      U8_OWE_ONE: begin
        state_o = U8_LEAD;
        bad_o   = !cont;
      end
      U8_OWE_TWO: begin
        state_o = U8_OWE_ONE;
        bad_o   = !cont;
      end
      U8_AFTER_E0: begin
        state_o = U8_OWE_ONE;
        bad_o   = !(byte_i >= 8'hA0 && byte_i <= 8'hBF);
      end
      U8_AFTER_ED: begin
        state_o = U8_OWE_ONE;
        bad_o   = !(byte_i >= 8'h80 && byte_i <= 8'h9F);
      end
      U8_AFTER_F0: begin
        state_o = U8_OWE_TWO;
        bad_o   = !(byte_i >= 8'h90 && byte_i <= 8'hBF);
      end
      U8_AFTER_F13: begin
        state_o = U8_OWE_TWO;
        bad_o   = !cont;
      end
      default: begin // after F4
        state_o = U8_OWE_TWO;
        bad_o   = !(byte_i >= 8'h80 && byte_i <= 8'h8F);
      end
    endcase
  end

endmodule

// ===== design/header_length_message_deframer_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// header_length_message_deframer_unit
// splits a byte stream into header lines and a length-sized payload
// ----------------------------------------------------------------------------
// Bytes enter one item at a time. Up to a blank line each byte is a header
// byte (kind 0) and each newline closes a header line (kind 1). Every
// header line must be strict utf-8 and hold a colon directly followed by a
// space. The first line starting with "Length: " gives the payload size in
// decimal; none means size 0. The blank line gives kind 3 with the size on
// payload_length, then that many payload bytes (kind 2) follow. tlast marks
// the item that completes a message. Any breach gives kind 4 and the block
// then answers every byte with kind 4 until reset. Exactly one result item
// comes out for every input item, in order. Throughput is one item per
// clock while the sink keeps taking; items pass the input register, then
// the single state-update stage into the output register, which frees as
// it is taken, so a stalled sink costs no bubble once it takes again.
// ----------------------------------------------------------------------------
module header_length_message_deframer_unit
  import hlmd_pkg::*;
#(
  parameter int unsigned LENGTH_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] in_byte

  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [7:0] data, [39:8] payload_length
  output logic [2:0]  out_tuser,  // [2:0] kind
  output logic        out_tlast   // message_done
);

  // ---------------- input register ----------------
  logic       in_v_r;
  logic [7:0] in_byte_r;
  logic       advance;

  // an item moves on when the output register is empty or being emptied
  assign advance   = in_v_r && (!out_tvalid || out_tready);
  assign in_tready = !in_v_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tready) begin
      in_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r <= in_tdata;
    end
  end

  // ---------------- parser state ----------------
  phase_t                 phase_r,        phase_nxt;
  logic                   broken_r,       broken_nxt;
  logic                   nonempty_r,     nonempty_nxt;
  logic                   colon_r,        colon_nxt;
  logic                   space_pend_r,   space_pend_nxt;
  logic                   sep_ok_r,       sep_ok_nxt;
  logic [3:0]             prefix_pos_r,   prefix_pos_nxt;
  logic                   prefix_dead_r,  prefix_dead_nxt;
  logic                   found_r,        found_nxt;
  logic                   digits_bad_r,   digits_bad_nxt;
  // parsed size while reading headers, bytes still owed during payload
  logic [LENGTH_BITS-1:0] len_r,          len_nxt;
  utf8_state_t            utf8_r,         utf8_nxt;

  // result of the current item
  kind_t                  res_kind;
  logic [7:0]             res_data;
  logic                   res_last;
  logic [LENGTH_BITS-1:0] res_size;

  // utf-8 step for the byte in hand
  utf8_state_t u8_next;
  logic        u8_bad;

  hlmd_utf8 u_utf8 (
    .state_i (utf8_r),
    .byte_i  (in_byte_r),
    .state_o (u8_next),
    .bad_o   (u8_bad)
  );

  // decimal accumulate: len*10 + digit, four guard bits catch overflow
  logic [LENGTH_BITS+3:0] len_x10;
  logic                   len_ovf;
  logic                   is_digit;

  assign len_x10 = {1'b0, len_r, 3'b000} + {3'b000, len_r, 1'b0}
                 + {LENGTH_BITS'(0), in_byte_r[3:0]};
  assign len_ovf  = |len_x10[LENGTH_BITS+3:LENGTH_BITS];
  assign is_digit = (in_byte_r >= CHR_ZERO) && (in_byte_r <= CHR_NINE);

  logic [LENGTH_BITS-1:0] size_sel;
  assign size_sel = found_r ? len_r : '0;

  always_comb begin
    phase_nxt       = phase_r;
    broken_nxt      = broken_r;
    nonempty_nxt    = nonempty_r;
    colon_nxt       = colon_r;
    space_pend_nxt  = space_pend_r;
    sep_ok_nxt      = sep_ok_r;
    prefix_pos_nxt  = prefix_pos_r;
    prefix_dead_nxt = prefix_dead_r;
    found_nxt       = found_r;
    digits_bad_nxt  = digits_bad_r;
    len_nxt         = len_r;
    utf8_nxt        = utf8_r;

    res_kind = KIND_MALFORMED;
    res_data = 8'h00;
    res_last = 1'b0;
    res_size = '0;

    if (broken_r) begin
      // sticky malformed: defaults already say so
    end else if (phase_r == PH_PAYLOAD) begin
      res_kind = KIND_PAY_BYTE;
      res_data = in_byte_r;
      if (len_r == LENGTH_BITS'(1)) begin
        // last payload byte, start over on a fresh message
        res_last        = 1'b1;
        phase_nxt       = PH_HEADERS;
        found_nxt       = 1'b0;
        digits_bad_nxt  = 1'b0;
        len_nxt         = '0;
        nonempty_nxt    = 1'b0;
        colon_nxt       = 1'b0;
        space_pend_nxt  = 1'b0;
        sep_ok_nxt      = 1'b0;
        prefix_pos_nxt  = '0;
        prefix_dead_nxt = 1'b0;
        utf8_nxt        = U8_LEAD;
      end else begin
        len_nxt = len_r - LENGTH_BITS'(1);
      end
    end else if (in_byte_r == CHR_LF) begin
      if (nonempty_r) begin
        // end of a header line
        if (!colon_r || !sep_ok_r || utf8_r != U8_LEAD) begin
          broken_nxt = 1'b1;
        end else begin
          res_kind = KIND_HDR_END;
          if (!found_r && !prefix_dead_r && prefix_pos_r == 4'(PREFIX_LEN)) begin
            found_nxt = 1'b1;
          end
          nonempty_nxt    = 1'b0;
          colon_nxt       = 1'b0;
          space_pend_nxt  = 1'b0;
          sep_ok_nxt      = 1'b0;
          prefix_pos_nxt  = '0;
          prefix_dead_nxt = 1'b0;
          utf8_nxt        = U8_LEAD;
        end
      end else if (digits_bad_r) begin
        broken_nxt = 1'b1;
      end else begin
        // blank line: headers are over
        res_kind        = KIND_HDRS_DONE;
        nonempty_nxt    = 1'b0;
        colon_nxt       = 1'b0;
        space_pend_nxt  = 1'b0;
        sep_ok_nxt      = 1'b0;
        prefix_pos_nxt  = '0;
        prefix_dead_nxt = 1'b0;
        utf8_nxt        = U8_LEAD;
        if (size_sel == '0) begin
          res_last       = 1'b1;
          found_nxt      = 1'b0;
          digits_bad_nxt = 1'b0;
          len_nxt        = '0;
        end else begin
          res_size  = size_sel;
          len_nxt   = size_sel;
          phase_nxt = PH_PAYLOAD;
        end
      end
    end else if (u8_bad) begin
      broken_nxt = 1'b1;
    end else begin
      // ordinary header byte
      res_kind     = KIND_HDR_BYTE;
      res_data     = in_byte_r;
      utf8_nxt     = u8_next;
      nonempty_nxt = 1'b1;
      if (space_pend_r) begin
        sep_ok_nxt     = (in_byte_r == CHR_SPACE);
        space_pend_nxt = 1'b0;
      end
      if (!colon_r && in_byte_r == CHR_COLON) begin
        colon_nxt      = 1'b1;
        space_pend_nxt = 1'b1;
      end
      if (!found_r && !prefix_dead_r) begin
        if (prefix_pos_r < 4'(PREFIX_LEN)) begin
          if (in_byte_r == prefix_char(prefix_pos_r[2:0])) begin
            prefix_pos_nxt = prefix_pos_r + 4'd1;
          end else begin
            prefix_dead_nxt = 1'b1;
          end
        end else if (is_digit) begin
          if (len_ovf) begin
            // saturate and flag
            len_nxt        = '1;
            digits_bad_nxt = 1'b1;
          end else begin
            len_nxt = len_x10[LENGTH_BITS-1:0];
          end
        end else begin
          digits_bad_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_HEADERS;
      broken_r      <= 1'b0;
      nonempty_r    <= 1'b0;
      colon_r       <= 1'b0;
      space_pend_r  <= 1'b0;
      sep_ok_r      <= 1'b0;
      prefix_pos_r  <= '0;
      prefix_dead_r <= 1'b0;
      found_r       <= 1'b0;
      digits_bad_r  <= 1'b0;
      len_r         <= '0;
      utf8_r        <= U8_LEAD;
    end else if (advance) begin
      phase_r       <= phase_nxt;
      broken_r      <= broken_nxt;
      nonempty_r    <= nonempty_nxt;
      colon_r       <= colon_nxt;
      space_pend_r  <= space_pend_nxt;
      sep_ok_r      <= sep_ok_nxt;
      prefix_pos_r  <= prefix_pos_nxt;
      prefix_dead_r <= prefix_dead_nxt;
      found_r       <= found_nxt;
      digits_bad_r  <= digits_bad_nxt;
      len_r         <= len_nxt;
      utf8_r        <= utf8_nxt;
    end
  end

  // ---------------- output register ----------------
  logic                    out_v_r;
  kind_t                   out_kind_r;
  logic [7:0]              out_data_r;
  logic                    out_last_r;
  logic [31:0]             out_plen_r;
  logic [LENGTH_BITS+31:0] size_ext;

  // size as reported is its low 32 bits
  assign size_ext = {32'd0, res_size};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (advance) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_kind_r <= res_kind;
      out_data_r <= res_data;
      out_last_r <= res_last;
      out_plen_r <= size_ext[31:0];
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {out_plen_r, out_data_r};
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

  // ---------------- assertions ----------------
  // malformed is sticky until reset
  a_broken_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    broken_r |=> broken_r)
    else $error("malformed flag cleared without reset");

  // once broken, every item that moves on reports malformed
  a_broken_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (broken_r && advance) |=> (out_kind_r == KIND_MALFORMED && !out_last_r))
    else $error("broken block produced a non-malformed item");

  // payload phase always owes at least one byte
  a_payload_owed: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_PAYLOAD) |-> (len_r != '0))
    else $error("payload phase with nothing owed");

  // prefix matcher never runs past "Length: "
  a_prefix_range: assert property (@(posedge clk) disable iff (!rst_n)
    prefix_pos_r <= 4'(PREFIX_LEN))
    else $error("prefix position out of range");

endmodule

// ===== bench/tb_header_length_message_deframer_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_header_length_message_deframer_unit
// self-checking bench for the header/length message deframer
// ----------------------------------------------------------------------------
// A queue of bytes is built up front: a few hand-picked messages, then
// random well-formed messages (utf-8 header text, Length headers with and
// without digits, look-alike and repeated Length headers, zero and non-zero
// payloads), and at the very end one malformed message followed by noise,
// since the error state only clears on reset. A falling-edge driver feeds
// the bytes with random gaps; a rising-edge monitor runs its own model of
// the deframer on every accepted byte and checks each result item in order.
// ----------------------------------------------------------------------------
module tb_header_length_message_deframer_unit;
  import hlmd_pkg::*;

  localparam int          IDLE_LIMIT = 1000;  // cycles with no item moving
  localparam logic [31:0] LEN_MAX    = 32'hFFFF_FFFF;
  localparam logic [63:0] LEN_TAG    = "Length: ";

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data;
    logic        done;
    logic [31:0] plen;
  } result_t;

  typedef struct {
    logic [7:0] value;
    bit         drain_first;  // hold this item back until all results are in
  } rx_item_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;   // [7:0] in_byte
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;          // [7:0] data, [39:8] payload_length
  logic [2:0]  out_tuser;          // [2:0] kind
  logic        out_tlast;          // message_done

  rx_item_t rx_stream[$];     // bytes still to be sent
  result_t  due_results[$];   // predicted result items, oldest first
  int       errors = 0;
  int       cyc = 0;
  bit       quiet = 1'b0;     // no idling on either side while set
  bit       in_fire = 1'b0;   // input item taken at the last rising edge
  bit       drain_next = 1'b0;

  // model state of the deframer
  phase_t      rx_phase;
  bit          rx_broken;
  bit          line_used, colon_hit, space_owed, sep_good;
  int          tag_pos;
  bit          tag_missed, len_known, len_bad;
  logic [31:0] len_value, pay_seen;
  utf8_state_t u8_st;

  header_length_message_deframer_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // model of the deframer
  // --------------------------------------------------------------------------
  function automatic void clear_line_state();
    line_used  = 1'b0;
    colon_hit  = 1'b0;
    space_owed = 1'b0;
    sep_good   = 1'b0;
    tag_pos    = 0;
    tag_missed = 1'b0;
    u8_st      = U8_LEAD;
  endfunction

  function automatic void clear_message_state();
    rx_phase  = PH_HEADERS;
    clear_line_state();
    len_known = 1'b0;
    len_bad   = 1'b0;
    len_value = '0;
    pay_seen  = '0;
  endfunction

  // works out the result item caused by one received byte
  function automatic result_t deframe_byte(input logic [7:0] b);
    result_t     r;
    utf8_state_t nxt;
    bit          bad;
    logic [31:0] dig;
    r = '{kind: KIND_MALFORMED, data: 8'h00, done: 1'b0, plen: 32'h0};
    if (rx_broken) return r;

    // payload: count bytes out, last one closes the message
    if (rx_phase == PH_PAYLOAD) begin
      pay_seen++;
      r.kind = KIND_PAY_BYTE;
      r.data = b;
      if (pay_seen >= len_value) begin
        r.done = 1'b1;
        clear_message_state();
      end
      return r;
    end

    if (b == CHR_LF) begin
      // end of a header line
      if (line_used) begin
        if (!colon_hit || !sep_good || u8_st != U8_LEAD) begin
          rx_broken = 1'b1;
          return r;
        end
        if (!len_known && !tag_missed && tag_pos == PREFIX_LEN) len_known = 1'b1;
        clear_line_state();
        r.kind = KIND_HDR_END;
        return r;
      end
      // blank line: end of headers
      if (len_bad) begin
        rx_broken = 1'b1;
        return r;
      end
      r.kind = KIND_HDRS_DONE;
      if (!len_known || len_value == 0) begin
        r.done = 1'b1;
        clear_message_state();
        return r;
      end
      r.plen   = len_value;
      rx_phase = PH_PAYLOAD;
      pay_seen = '0;
      clear_line_state();
      return r;
    end

    // strict utf-8: no overlongs, no surrogates, nothing above U+10FFFF
    bad = 1'b0;
    nxt = U8_LEAD;
    case (u8_st)
      U8_LEAD: begin
        if (b < 8'h80)                     nxt = U8_LEAD;
        else if (b >= 8'hC2 && b <= 8'hDF) nxt = U8_OWE_ONE;
        else if (b == 8'hE0)               nxt = U8_AFTER_E0;
        else if (b == 8'hED)               nxt = U8_AFTER_ED;
        else if (b >= 8'hE1 && b <= 8'hEF) nxt = U8_OWE_TWO;
        else if (b == 8'hF0)               nxt = U8_AFTER_F0;
        else if (b >= 8'hF1 && b <= 8'hF3) nxt = U8_AFTER_F13;
        else if (b == 8'hF4)               nxt = U8_AFTER_F4;
        else                               bad = 1'b1;
      end
      U8_OWE_ONE:   if (b[7:6] == 2'b10) nxt = U8_LEAD; else bad = 1'b1;
      U8_OWE_TWO:   if (b[7:6] == 2'b10) nxt = U8_OWE_ONE; else bad = 1'b1;
      U8_AFTER_E0:  if (b >= 8'hA0 && b <= 8'hBF) nxt = U8_OWE_ONE; else bad = 1'b1;
      U8_AFTER_ED:  if (b >= 8'h80 && b <= 8'h9F) nxt = U8_OWE_ONE; else bad = 1'b1;
      U8_AFTER_F0:  if (b >= 8'h90 && b <= 8'hBF) nxt = U8_OWE_TWO; else bad = 1'b1;
      U8_AFTER_F13: if (b[7:6] == 2'b10) nxt = U8_OWE_TWO; else bad = 1'b1;
      default:      if (b >= 8'h80 && b <= 8'h8F) nxt = U8_OWE_TWO; else bad = 1'b1;
    endcase
    if (bad) begin
      rx_broken = 1'b1;
      return r;
    end
    u8_st     = nxt;
    line_used = 1'b1;

    // the byte straight after the first colon must be a space
    if (space_owed) begin
      sep_good   = (b == CHR_SPACE);
      space_owed = 1'b0;
    end
    if (!colon_hit && b == CHR_COLON) begin
      colon_hit  = 1'b1;
      space_owed = 1'b1;
    end

    // match "Length: " from the start of the line, then take digits
    if (!len_known && !tag_missed) begin
      if (tag_pos < PREFIX_LEN) begin
        if (b == LEN_TAG[63 - 8*tag_pos -: 8]) tag_pos++;
        else tag_missed = 1'b1;
      end else if (b >= CHR_ZERO && b <= CHR_NINE) begin
        dig = {24'd0, b - CHR_ZERO};
        if (len_value > (LEN_MAX - dig) / 32'd10) begin
          len_value = LEN_MAX;
          len_bad   = 1'b1;
        end else begin
          len_value = len_value * 32'd10 + dig;
        end
      end else begin
        len_bad = 1'b1;
      end
    end
    r.kind = KIND_HDR_BYTE;
    r.data = b;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // byte stream builders
  // --------------------------------------------------------------------------
  function automatic void push_byte(input logic [7:0] b);
    rx_item_t it;
    it.value       = b;
    it.drain_first = drain_next;
    drain_next     = 1'b0;
    rx_stream.push_back(it);
  endfunction

  function automatic void push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endfunction

  function automatic logic [7:0] cont_byte();
    return 8'($urandom_range(8'h80, 8'hBF));
  endfunction

  // one well-formed utf-8 character, never a newline
  function automatic void push_char(input bit no_colon);
    logic [7:0] c;
    case ($urandom_range(0, 9))
      6: begin
        push_byte(8'($urandom_range(8'hC2, 8'hDF)));
        push_byte(cont_byte());
      end
      7: begin
        case ($urandom_range(0, 2))
          0: begin push_byte(8'hE0); push_byte(8'($urandom_range(8'hA0, 8'hBF))); end
          1: begin push_byte(8'hED); push_byte(8'($urandom_range(8'h80, 8'h9F))); end
          default: begin
            c = 8'($urandom_range(8'hE1, 8'hEE));
            push_byte(c == 8'hED ? 8'hEF : c);
            push_byte(cont_byte());
          end
        endcase
        push_byte(cont_byte());
      end
      8: begin
        case ($urandom_range(0, 2))
          0: begin push_byte(8'hF0); push_byte(8'($urandom_range(8'h90, 8'hBF))); end
          1: begin
            push_byte(8'($urandom_range(8'hF1, 8'hF3)));
            push_byte(cont_byte());
          end
          default: begin push_byte(8'hF4); push_byte(8'($urandom_range(8'h80, 8'h8F))); end
        endcase
        push_byte(cont_byte());
        push_byte(cont_byte());
      end
      9: begin
        // ascii edges, nul included
        case ($urandom_range(0, 2))
          0:       push_byte(8'h00);
          1:       push_byte(8'h7F);
          default: push_byte(CHR_SPACE);
        endcase
      end
      default: begin
        c = 8'($urandom_range(0, 127));
        while (c == CHR_LF || (no_colon && c == CHR_COLON)) c = 8'($urandom_range(0, 127));
        push_byte(c);
      end
    endcase
  endfunction

  function automatic void push_length_line(input int unsigned v, input bit no_digits);
    push_text("Length: ");
    if (!no_digits) begin
      repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 2) : 0) push_byte(CHR_ZERO);
      push_text($sformatf("%0d", v));
    end
    push_byte(CHR_LF);
  endfunction

  // a complete well-formed message with random content
  function automatic void push_message();
    int unsigned n_hdr, len_at, size;
    bit          has_len, no_digits;
    n_hdr     = $urandom_range(0, 4);
    len_at    = $urandom_range(0, n_hdr);
    has_len   = $urandom_range(0, 3) != 0;
    no_digits = $urandom_range(0, 9) == 0;
    size      = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 12);
    if (no_digits) size = 0;
    for (int i = 0; i <= n_hdr; i++) begin
      if (has_len && i == len_at) begin
        push_length_line(size, no_digits);
      end else if (has_len && i > len_at && $urandom_range(0, 2) == 0) begin
        // later Length headers are ignored
        push_length_line($urandom_range(0, 999), 1'b0);
      end else if (i < n_hdr) begin
        case ($urandom_range(0, 9))
          0: push_text("Lengthy");
          1: push_text("length");
          2: push_text("Len");
          3: push_text("Length-Type");
          default: repeat ($urandom_range(0, 6)) push_char(1'b1);
        endcase
        push_text(": ");
        repeat ($urandom_range(0, 6)) push_char(1'b0);
        push_byte(CHR_LF);
      end
    end
    push_byte(CHR_LF);
    if (has_len) repeat (size) push_byte(8'($urandom_range(0, 255)));
  endfunction

  // one breach of the framing rules, then noise while the block is stuck
  function automatic void push_breach();
    case ($urandom_range(0, 6))
      0: begin
        push_text("x: ");
        case ($urandom_range(0, 2))
          0:       push_byte(8'($urandom_range(8'hC0, 8'hC1)));
          1:       push_byte(8'($urandom_range(8'hF5, 8'hFF)));
          default: push_byte(cont_byte());
        endcase
      end
      1: begin
        push_text("x: ");
        if ($urandom_range(0, 1) != 0) begin
          push_byte(8'hE0);
          push_byte(8'($urandom_range(8'h80, 8'h9F)));
        end else begin
          push_byte(8'hC3);
          push_byte(8'h41);
        end
      end
      2: begin
        push_text("y: ");
        push_byte(8'hC3);
        push_byte(CHR_LF);
      end
      3: push_text("novalue\n");
      4: push_text("k:v\n");
      5: begin
        push_text("Length: 1");
        push_byte($urandom_range(0, 1) != 0 ? 8'h00 : 8'h78);
        push_text("\n\n");
      end
      default: push_text("Length: 99999999999\n\n");
    endcase
    repeat (16) push_byte(8'($urandom_range(0, 255)));
  endfunction

  // --------------------------------------------------------------------------
  // stimulus and end of run
  // --------------------------------------------------------------------------
  initial begin
    int n_msg;
    rx_broken = 1'b0;
    clear_message_state();

    // hand-picked: plain header, Length 3, payload with byte extremes and a
    // newline, then a message with no headers at all (zero payload)
    push_text("a: b\n");
    push_text("Length: 3\n\n");
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(CHR_LF);
    push_byte(CHR_LF);

    n_msg = 0;
    while (rx_stream.size() < 480) begin
      if (n_msg % 20 == 3) drain_next = 1'b1;
      push_message();
      n_msg++;
    end
    drain_next = 1'b1;
    push_breach();

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    while (rx_stream.size() != 0 || in_tvalid || due_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("tb_header_length_message_deframer_unit: PASS");
    end else begin
      $display("tb_header_length_message_deframer_unit: FAIL");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // driver: changes inputs on the falling edge
  // --------------------------------------------------------------------------
  always @(negedge clk) begin : drive
    bit       send;
    rx_item_t nxt_item;
    if (!rst_n) begin
      in_tvalid  <= 1'b0;
      out_tready <= 1'b0;
    end else begin
      cyc++;
      quiet = (cyc >= 200 && cyc < 400);
      // an item on offer stays until it is taken
      send = in_tvalid && !in_fire;
      if (!send && rx_stream.size() != 0) begin
        if (rx_stream[0].drain_first) begin
          if (due_results.size() == 0) rx_stream[0].drain_first = 1'b0;
        end else if (quiet || $urandom_range(0, 99) >= 20) begin
          nxt_item = rx_stream.pop_front();
          in_tdata <= nxt_item.value;
          send     = 1'b1;
        end
      end
      in_tvalid  <= send;
      out_tready <= quiet || ($urandom_range(0, 99) >= 20);
    end
  end

  // --------------------------------------------------------------------------
  // monitor: samples on the rising edge, predicts and checks
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : watch
    result_t want;
    if (!rst_n) begin
      in_fire = 1'b0;
    end else begin
      // check first, so a result can never match a byte taken this edge
      if (out_tvalid && out_tready) begin
        if (due_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, got kind=%0d data=%02h last=%0b length=%0d",
                   $time, out_tuser, out_tdata[7:0], out_tlast, out_tdata[39:8]);
        end else begin
          want = due_results.pop_front();
          if (out_tuser !== want.kind || out_tdata[7:0] !== want.data ||
              out_tlast !== want.done || out_tdata[39:8] !== want.plen) begin
            errors++;
            $display("%0t: mismatch, expected kind=%0d data=%02h last=%0b length=%0d",
                     $time, want.kind, want.data, want.done, want.plen);
            $display("%0t:           got      kind=%0d data=%02h last=%0b length=%0d",
                     $time, out_tuser, out_tdata[7:0], out_tlast, out_tdata[39:8]);
          end
        end
      end
      in_fire = in_tvalid && in_tready;
      if (in_fire) due_results.push_back(deframe_byte(in_tdata));
    end
  end

  // --------------------------------------------------------------------------
  // watchdog: too long with no item moving on either side
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : dog
    int stuck;
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stuck = 0;
    end else begin
      stuck++;
      if (stuck >= IDLE_LIMIT) begin
        $display("%0t: no item moved for %0d cycles", $time, IDLE_LIMIT);
        $display("tb_header_length_message_deframer_unit: FAIL");
        $finish;
      end
    end
  end

endmodule
